// ----- sv/line_segment_clipper_unit_defines.svh -----
// assertion macros for the line segment clipper checker
// expects clk_i and rst_ni in the scope of each use
`ifndef LINE_SEGMENT_CLIPPER_UNIT_DEFINES_SVH
`define LINE_SEGMENT_CLIPPER_UNIT_DEFINES_SVH

// same-cycle implication
`define LSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lsc_pkg.sv -----
// shared constants, types and state encoding for the line segment clipper
// no dependencies
package lsc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int MAX_PASSES_DEF  = 8;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CFG_IDX_WIDTH   = 2;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_WINDOW_LEFT   = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_WINDOW_TOP    = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_WINDOW_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_WINDOW_BOTTOM = 2'd3;

  // window reset values
  localparam longint WIN_LEFT_RST   = 0;
  localparam longint WIN_TOP_RST    = 0;
  localparam longint WIN_RIGHT_RST  = 959;
  localparam longint WIN_BOTTOM_RST = 539;

  // region code bits
  localparam logic [3:0] CODE_LEFT   = 4'h1;
  localparam logic [3:0] CODE_RIGHT  = 4'h2;
  localparam logic [3:0] CODE_TOP    = 4'h4;
  localparam logic [3:0] CODE_BOTTOM = 4'h8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_DIV,
    ST_UPDATE,
    ST_CODE
  } back_state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_sts_t;

endpackage

// ----- sv/line_segment_clipper_unit.sv -----
// line segment clipper top level: front, queue and back; depends on lsc_pkg
// per segment: p moves in the back end, p up to MAX_PASSES;
// each move is set by the bit-serial divider (one quotient bit a cycle)
// reset is asynchronous and active low: queue and result emptied, window set to 0, 0, 959, 539
module line_segment_clipper_unit #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF,
  parameter int MAX_PASSES  = lsc_pkg::MAX_PASSES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [lsc_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic        [COORD_WIDTH-1:0]        cfg_data_i,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [COORD_WIDTH-1:0]        start_x_i,
  input  logic signed [COORD_WIDTH-1:0]        start_y_i,
  input  logic signed [COORD_WIDTH-1:0]        end_x_i,
  input  logic signed [COORD_WIDTH-1:0]        end_y_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 visible_o,
  output logic signed [COORD_WIDTH-1:0]        clipped_start_x_o,
  output logic signed [COORD_WIDTH-1:0]        clipped_start_y_o,
  output logic signed [COORD_WIDTH-1:0]        clipped_end_x_o,
  output logic signed [COORD_WIDTH-1:0]        clipped_end_y_o
);

  localparam int ItemWidth = 4 * COORD_WIDTH + 8;

  logic signed [COORD_WIDTH-1:0] win_left, win_top, win_right, win_bottom;
  logic [ItemWidth-1:0] front_data, queue_data;
  logic                 front_push, back_pop, res_valid;
  lsc_pkg::fifo_req_t   q_req;
  lsc_pkg::fifo_sts_t   q_sts;

  assign q_req.push = front_push;
  assign q_req.pop  = back_pop;
  assign full       = q_sts.full;
  assign empty      = !res_valid;

  lsc_front #(.COORD_WIDTH(COORD_WIDTH), .ItemWidth(ItemWidth)) u_front (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push_i(push), .full_i(q_sts.full),
    .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .win_left_o(win_left), .win_top_o(win_top),
    .win_right_o(win_right), .win_bottom_o(win_bottom),
    .q_push_o(front_push), .q_data_o(front_data)
  );

  lsc_queue #(.ItemWidth(ItemWidth), .Depth(lsc_pkg::QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .req_i(q_req), .sts_o(q_sts),
    .data_i(front_data), .data_o(queue_data)
  );

  lsc_back #(
    .COORD_WIDTH(COORD_WIDTH), .MAX_PASSES(MAX_PASSES), .ItemWidth(ItemWidth)
  ) u_back (
    .clk_i, .rst_ni,
    .win_left_i(win_left), .win_top_i(win_top),
    .win_right_i(win_right), .win_bottom_i(win_bottom),
    .q_empty_i(q_sts.empty), .q_data_i(queue_data), .q_pop_o(back_pop),
    .res_pop_i(pop && res_valid),
    .res_valid_o(res_valid),
    .res_visible_o(visible_o),
    .res_start_x_o(clipped_start_x_o), .res_start_y_o(clipped_start_y_o),
    .res_end_x_o(clipped_end_x_o), .res_end_y_o(clipped_end_y_o)
  );

endmodule

// ----- sv/lsc_region.sv -----
// four-bit region code of one point against the clip window
// depends on lsc_pkg
module lsc_region #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
) (
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  input  logic signed [COORD_WIDTH-1:0] win_left_i,
  input  logic signed [COORD_WIDTH-1:0] win_top_i,
  input  logic signed [COORD_WIDTH-1:0] win_right_i,
  input  logic signed [COORD_WIDTH-1:0] win_bottom_i,
  output logic        [3:0]             code_o
);

  always_comb begin
    code_o = '0;
    if (x_i < win_left_i) begin
      code_o = code_o | lsc_pkg::CODE_LEFT;
    end else if (x_i > win_right_i) begin
      code_o = code_o | lsc_pkg::CODE_RIGHT;
    end
    if (y_i < win_top_i) begin
      code_o = code_o | lsc_pkg::CODE_TOP;
    end else if (y_i > win_bottom_i) begin
      code_o = code_o | lsc_pkg::CODE_BOTTOM;
    end
  end

endmodule

// ----- sv/lsc_front.sv -----
// front end: window registers, input acceptance and region coding of both endpoints
// depends on lsc_pkg and lsc_region
module lsc_front #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF,
  parameter int ItemWidth   = 4 * COORD_WIDTH + 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [lsc_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic        [COORD_WIDTH-1:0]        cfg_data_i,
  input  logic                                 push_i,
  input  logic                                 full_i,
  input  logic signed [COORD_WIDTH-1:0]        start_x_i,
  input  logic signed [COORD_WIDTH-1:0]        start_y_i,
  input  logic signed [COORD_WIDTH-1:0]        end_x_i,
  input  logic signed [COORD_WIDTH-1:0]        end_y_i,
  output logic signed [COORD_WIDTH-1:0]        win_left_o,
  output logic signed [COORD_WIDTH-1:0]        win_top_o,
  output logic signed [COORD_WIDTH-1:0]        win_right_o,
  output logic signed [COORD_WIDTH-1:0]        win_bottom_o,
  output logic                                 q_push_o,
  output logic        [ItemWidth-1:0]          q_data_o
);

  localparam longint CoordMax = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;

  // reset values clamp at the top of the coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] rst_val(input longint v);
    rst_val = (v > CoordMax) ? COORD_WIDTH'(CoordMax) : COORD_WIDTH'(v);
  endfunction

  logic signed [COORD_WIDTH-1:0] win_left_q, win_top_q, win_right_q, win_bottom_q;
  logic [3:0] code_start, code_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= rst_val(lsc_pkg::WIN_LEFT_RST);
      win_top_q    <= rst_val(lsc_pkg::WIN_TOP_RST);
      win_right_q  <= rst_val(lsc_pkg::WIN_RIGHT_RST);
      win_bottom_q <= rst_val(lsc_pkg::WIN_BOTTOM_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsc_pkg::REG_WINDOW_LEFT:   win_left_q   <= cfg_data_i;
        lsc_pkg::REG_WINDOW_TOP:    win_top_q    <= cfg_data_i;
        lsc_pkg::REG_WINDOW_RIGHT:  win_right_q  <= cfg_data_i;
        lsc_pkg::REG_WINDOW_BOTTOM: win_bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lsc_region #(.COORD_WIDTH(COORD_WIDTH)) u_region_start (
    .x_i(start_x_i), .y_i(start_y_i),
    .win_left_i(win_left_q), .win_top_i(win_top_q),
    .win_right_i(win_right_q), .win_bottom_i(win_bottom_q),
    .code_o(code_start)
  );

  lsc_region #(.COORD_WIDTH(COORD_WIDTH)) u_region_end (
    .x_i(end_x_i), .y_i(end_y_i),
    .win_left_i(win_left_q), .win_top_i(win_top_q),
    .win_right_i(win_right_q), .win_bottom_i(win_bottom_q),
    .code_o(code_end)
  );

  assign win_left_o   = win_left_q;
  assign win_top_o    = win_top_q;
  assign win_right_o  = win_right_q;
  assign win_bottom_o = win_bottom_q;

  assign q_push_o = push_i && !full_i;
  assign q_data_o = {start_x_i, start_y_i, end_x_i, end_y_i, code_start, code_end};

endmodule

// ----- sv/lsc_queue.sv -----
// short queue of classified segments between front and back
// depends on lsc_pkg
module lsc_queue #(
  parameter int ItemWidth = 4 * lsc_pkg::COORD_WIDTH_DEF + 8,
  parameter int Depth     = lsc_pkg::QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lsc_pkg::fifo_req_t       req_i,
  output lsc_pkg::fifo_sts_t       sts_o,
  input  logic [ItemWidth-1:0]     data_i,
  output logic [ItemWidth-1:0]     data_o
);

  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntWidth = $clog2(Depth + 1);

  logic [ItemWidth-1:0] mem_q [Depth];
  logic [PtrWidth-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]  count_q, count_d;
  logic                 do_push, do_pop;

  assign sts_o.full  = (count_q == CntWidth'(Depth));
  assign sts_o.empty = (count_q == '0);
  assign do_push     = req_i.push && !sts_o.full;
  assign do_pop      = req_i.pop && !sts_o.empty;
  assign data_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/lsc_back.sv -----
// back end: clip pass sequencer with shared multiplier, bit-serial divider and result register
// depends on lsc_pkg and lsc_region
module lsc_back #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF,
  parameter int MAX_PASSES  = lsc_pkg::MAX_PASSES_DEF,
  parameter int ItemWidth   = 4 * COORD_WIDTH + 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [COORD_WIDTH-1:0] win_left_i,
  input  logic signed [COORD_WIDTH-1:0] win_top_i,
  input  logic signed [COORD_WIDTH-1:0] win_right_i,
  input  logic signed [COORD_WIDTH-1:0] win_bottom_i,
  input  logic                          q_empty_i,
  input  logic        [ItemWidth-1:0]   q_data_i,
  output logic                          q_pop_o,
  input  logic                          res_pop_i,
  output logic                          res_valid_o,
  output logic                          res_visible_o,
  output logic signed [COORD_WIDTH-1:0] res_start_x_o,
  output logic signed [COORD_WIDTH-1:0] res_start_y_o,
  output logic signed [COORD_WIDTH-1:0] res_end_x_o,
  output logic signed [COORD_WIDTH-1:0] res_end_y_o
);

  localparam int W         = COORD_WIDTH;
  localparam int ProdWidth = 2 * W + 1;
  localparam int CntWidth  = $clog2(ProdWidth + 1);
  localparam int PassWidth = $clog2(MAX_PASSES + 1);

  lsc_pkg::back_state_e state_q, state_d;

  logic signed [W-1:0] ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic [3:0]          ca_q, ca_d, cb_q, cb_d;
  logic [PassWidth-1:0] pass_q, pass_d;

  logic [W:0]          mag_d_q, mag_d_d, mag_e_q, mag_e_d, den_q, den_d;
  logic                neg_q, neg_d, horiz_q, horiz_d, move_b_q, move_b_d;
  logic signed [W-1:0] base_q, base_d, edge_q, edge_d;

  logic [ProdWidth-1:0] dvd_q, dvd_d;
  logic [W:0]           rem_q, rem_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;

  logic                res_valid_q, res_valid_d, res_vis_q, res_vis_d;
  logic signed [W-1:0] res_sx_q, res_sx_d, res_sy_q, res_sy_d;
  logic signed [W-1:0] res_ex_q, res_ex_d, res_ey_q, res_ey_d;

  logic [3:0]          code_a, code_b, code_sel;
  logic signed [W:0]   dx, dy, op_d, op_e, op_den, den_fix;
  logic signed [W-1:0] op_base, op_edge;
  logic                op_horiz, decided, slot_free;
  logic [2*W+1:0]      prod;
  logic [W+1:0]        trial;
  logic [W:0]          q_clamp;
  logic signed [W+1:0] sum;
  logic signed [W-1:0] new_coord;

  lsc_region #(.COORD_WIDTH(W)) u_region_a (
    .x_i(ax_q), .y_i(ay_q),
    .win_left_i(win_left_i), .win_top_i(win_top_i),
    .win_right_i(win_right_i), .win_bottom_i(win_bottom_i),
    .code_o(code_a)
  );

  lsc_region #(.COORD_WIDTH(W)) u_region_b (
    .x_i(bx_q), .y_i(by_q),
    .win_left_i(win_left_i), .win_top_i(win_top_i),
    .win_right_i(win_right_i), .win_bottom_i(win_bottom_i),
    .code_o(code_b)
  );

  // edge selection and operands for the next move
  always_comb begin
    dx       = $signed({bx_q[W-1], bx_q}) - $signed({ax_q[W-1], ax_q});
    dy       = $signed({by_q[W-1], by_q}) - $signed({ay_q[W-1], ay_q});
    code_sel = (ca_q != '0) ? ca_q : cb_q;
    if ((code_sel & lsc_pkg::CODE_BOTTOM) != '0) begin
      op_horiz = 1'b1;
      op_base  = ax_q;
      op_d     = dx;
      op_e     = $signed({win_bottom_i[W-1], win_bottom_i}) - $signed({ay_q[W-1], ay_q});
      op_den   = dy;
      op_edge  = win_bottom_i;
    end else if ((code_sel & lsc_pkg::CODE_TOP) != '0) begin
      op_horiz = 1'b1;
      op_base  = ax_q;
      op_d     = dx;
      op_e     = $signed({win_top_i[W-1], win_top_i}) - $signed({ay_q[W-1], ay_q});
      op_den   = dy;
      op_edge  = win_top_i;
    end else if ((code_sel & lsc_pkg::CODE_RIGHT) != '0) begin
      op_horiz = 1'b0;
      op_base  = ay_q;
      op_d     = dy;
      op_e     = $signed({win_right_i[W-1], win_right_i}) - $signed({ax_q[W-1], ax_q});
      op_den   = dx;
      op_edge  = win_right_i;
    end else begin
      op_horiz = 1'b0;
      op_base  = ay_q;
      op_d     = dy;
      op_e     = $signed({win_left_i[W-1], win_left_i}) - $signed({ax_q[W-1], ax_q});
      op_den   = dx;
      op_edge  = win_left_i;
    end
    den_fix = (op_den == '0) ? (W+1)'(1) : op_den;
  end

  assign decided   = (pass_q == PassWidth'(MAX_PASSES)) || ((ca_q | cb_q) == '0) ||
                     ((ca_q & cb_q) != '0);
  assign slot_free = !res_valid_q || res_pop_i;
  assign prod      = mag_d_q * mag_e_q;
  assign trial     = {rem_q, dvd_q[ProdWidth-1]} - {1'b0, den_q};

  // clamp, apply sign and saturate
  always_comb begin
    q_clamp = (|dvd_q[ProdWidth-1:W]) ? {1'b1, {W{1'b0}}} : {1'b0, dvd_q[W-1:0]};
    sum     = neg_q ? ($signed({{2{base_q[W-1]}}, base_q}) - $signed({1'b0, q_clamp}))
                    : ($signed({{2{base_q[W-1]}}, base_q}) + $signed({1'b0, q_clamp}));
    if ((sum[W+1:W-1] == 3'b000) || (sum[W+1:W-1] == 3'b111)) begin
      new_coord = sum[W-1:0];
    end else if (sum[W+1]) begin
      new_coord = {1'b1, {(W-1){1'b0}}};
    end else begin
      new_coord = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    bx_d        = bx_q;
    by_d        = by_q;
    ca_d        = ca_q;
    cb_d        = cb_q;
    pass_d      = pass_q;
    mag_d_d     = mag_d_q;
    mag_e_d     = mag_e_q;
    den_d       = den_q;
    neg_d       = neg_q;
    horiz_d     = horiz_q;
    move_b_d    = move_b_q;
    base_d      = base_q;
    edge_d      = edge_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    res_valid_d = res_valid_q && !res_pop_i;
    res_vis_d   = res_vis_q;
    res_sx_d    = res_sx_q;
    res_sy_d    = res_sy_q;
    res_ex_d    = res_ex_q;
    res_ey_d    = res_ey_q;
    q_pop_o     = 1'b0;

    case (state_q)
      lsc_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          {ax_d, ay_d, bx_d, by_d, ca_d, cb_d} = q_data_i;
          pass_d  = '0;
          state_d = lsc_pkg::ST_DECIDE;
        end
      end
      lsc_pkg::ST_DECIDE: begin
        if (decided) begin
          if (slot_free) begin
            res_valid_d = 1'b1;
            if ((pass_q != PassWidth'(MAX_PASSES)) && ((ca_q | cb_q) == '0)) begin
              res_vis_d = 1'b1;
              res_sx_d  = ax_q;
              res_sy_d  = ay_q;
              res_ex_d  = bx_q;
              res_ey_d  = by_q;
            end else begin
              res_vis_d = 1'b0;
              res_sx_d  = '0;
              res_sy_d  = '0;
              res_ex_d  = '0;
              res_ey_d  = '0;
            end
            state_d = lsc_pkg::ST_IDLE;
          end
        end else begin
          mag_d_d  = op_d[W] ? (-op_d) : op_d;
          mag_e_d  = op_e[W] ? (-op_e) : op_e;
          den_d    = den_fix[W] ? (-den_fix) : den_fix;
          neg_d    = op_d[W] ^ op_e[W] ^ den_fix[W];
          horiz_d  = op_horiz;
          move_b_d = (ca_q == '0);
          base_d   = op_base;
          edge_d   = op_edge;
          state_d  = lsc_pkg::ST_MUL;
        end
      end
      lsc_pkg::ST_MUL: begin
        dvd_d   = prod[ProdWidth-1:0];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = lsc_pkg::ST_DIV;
      end
      lsc_pkg::ST_DIV: begin
        if (!trial[W+1]) begin
          rem_d = trial[W:0];
          dvd_d = {dvd_q[ProdWidth-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[W-1:0], dvd_q[ProdWidth-1]};
          dvd_d = {dvd_q[ProdWidth-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntWidth'(ProdWidth - 1)) begin
          state_d = lsc_pkg::ST_UPDATE;
        end
      end
      lsc_pkg::ST_UPDATE: begin
        if (move_b_q) begin
          bx_d = horiz_q ? new_coord : edge_q;
          by_d = horiz_q ? edge_q : new_coord;
        end else begin
          ax_d = horiz_q ? new_coord : edge_q;
          ay_d = horiz_q ? edge_q : new_coord;
        end
        pass_d  = pass_q + 1'b1;
        state_d = lsc_pkg::ST_CODE;
      end
      lsc_pkg::ST_CODE: begin
        ca_d    = code_a;
        cb_d    = code_b;
        state_d = lsc_pkg::ST_DECIDE;
      end
      default: begin
        state_d = lsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsc_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    bx_q     <= bx_d;
    by_q     <= by_d;
    ca_q     <= ca_d;
    cb_q     <= cb_d;
    pass_q   <= pass_d;
    mag_d_q  <= mag_d_d;
    mag_e_q  <= mag_e_d;
    den_q    <= den_d;
    neg_q    <= neg_d;
    horiz_q  <= horiz_d;
    move_b_q <= move_b_d;
    base_q   <= base_d;
    edge_q   <= edge_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
    res_vis_q <= res_vis_d;
    res_sx_q <= res_sx_d;
    res_sy_q <= res_sy_d;
    res_ex_q <= res_ex_d;
    res_ey_q <= res_ey_d;
  end

  assign res_valid_o   = res_valid_q;
  assign res_visible_o = res_vis_q;
  assign res_start_x_o = res_sx_q;
  assign res_start_y_o = res_sy_q;
  assign res_end_x_o   = res_ex_q;
  assign res_end_y_o   = res_ey_q;

endmodule

// ----- sv/lsc_checker.sv -----
// port-level checker for the line segment clipper, bound to the top level
// depends on lsc_pkg and line_segment_clipper_unit_defines.svh
`include "line_segment_clipper_unit_defines.svh"

module lsc_checker #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   push,
  input logic                   full,
  input logic                   empty,
  input logic                   pop,
  input logic                   visible_o,
  input logic [COORD_WIDTH-1:0] clipped_start_x_o,
  input logic [COORD_WIDTH-1:0] clipped_start_y_o,
  input logic [COORD_WIDTH-1:0] clipped_end_x_o,
  input logic [COORD_WIDTH-1:0] clipped_end_y_o
);

  localparam int OutWidth = $clog2(lsc_pkg::QUEUE_DEPTH + 3) + 1;

  logic [OutWidth-1:0] outstanding_q;
  logic                in_txn, out_txn;

  assign in_txn  = push && !full;
  assign out_txn = pop && !empty;

  // segments accepted whose result has not been taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else if (in_txn && !out_txn) begin
      outstanding_q <= outstanding_q + 1'b1;
    end else if (out_txn && !in_txn) begin
      outstanding_q <= outstanding_q - 1'b1;
    end
  end

  `LSC_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(visible_o) && $stable(clipped_start_x_o) && $stable(clipped_end_y_o), "result changed while stalled")
  `LSC_ASSERT_NOW(a_hidden_zero, !empty && !visible_o, (clipped_start_x_o == '0) && (clipped_start_y_o == '0) && (clipped_end_x_o == '0) && (clipped_end_y_o == '0), "hidden segment with nonzero coordinates")
  `LSC_ASSERT_NOW(a_no_phantom, !empty, outstanding_q != '0, "result without an accepted segment")
  `LSC_ASSERT_NOW(a_full_backed, full, outstanding_q >= OutWidth'(lsc_pkg::QUEUE_DEPTH), "full with too few segments in flight")

endmodule

bind line_segment_clipper_unit lsc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lsc_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .push(push),
  .full(full),
  .empty(empty),
  .pop(pop),
  .visible_o(visible_o),
  .clipped_start_x_o(clipped_start_x_o),
  .clipped_start_y_o(clipped_start_y_o),
  .clipped_end_x_o(clipped_end_x_o),
  .clipped_end_y_o(clipped_end_y_o)
);

// ----- dv/tb_line_segment_clipper_unit.sv -----
`timescale 1ns / 100ps
// self-checking testbench for line_segment_clipper_unit: queue driver and monitor
// with a built-in region-code clipping predictor; depends on lsc_pkg and the dut
module tb_line_segment_clipper_unit;

  localparam int CW           = lsc_pkg::COORD_WIDTH_DEF;
  localparam int PASS_LIMIT   = lsc_pkg::MAX_PASSES_DEF;
  localparam int DRAIN_CYCLES = 3 + PASS_LIMIT * (2 * CW + 5) + 20;
  localparam longint CMAX     = (longint'(1) << (CW - 1)) - 1;
  localparam longint CMIN     = -CMAX - 1;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } segment_t;
  typedef struct packed {
    logic   vis;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } clip_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [lsc_pkg::CFG_IDX_WIDTH-1:0] cfg_idx = lsc_pkg::REG_WINDOW_LEFT;
  logic [CW-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic pop = 1'b0;
  coord_t start_x = '0;
  coord_t start_y = '0;
  coord_t end_x = '0;
  coord_t end_y = '0;
  logic full;
  logic empty;
  logic visible;
  coord_t clip_sx;
  coord_t clip_sy;
  coord_t clip_ex;
  coord_t clip_ey;

  // window as currently held by the dut
  longint win_l = lsc_pkg::WIN_LEFT_RST;
  longint win_t = lsc_pkg::WIN_TOP_RST;
  longint win_r = lsc_pkg::WIN_RIGHT_RST;
  longint win_b = lsc_pkg::WIN_BOTTOM_RST;

  segment_t segment_pending_q[$];
  clip_t    clip_expected_q[$];

  int err_count = 0;
  int n_in = 0;
  int n_out = 0;
  int n_visible = 0;
  int n_windows = 0;
  int gap_rate = 20;
  bit calm = 1'b0;
  int push_gap = 0;
  int pop_gap = 0;

  line_segment_clipper_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .push              (push),
    .full              (full),
    .start_x_i         (start_x),
    .start_y_i         (start_y),
    .end_x_i           (end_x),
    .end_y_i           (end_y),
    .empty             (empty),
    .pop               (pop),
    .visible_o         (visible),
    .clipped_start_x_o (clip_sx),
    .clipped_start_y_o (clip_sy),
    .clipped_end_x_o   (clip_ex),
    .clipped_end_y_o   (clip_ey)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint sat_coord(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (x < win_l) c |= lsc_pkg::CODE_LEFT;
    else if (x > win_r) c |= lsc_pkg::CODE_RIGHT;
    if (y < win_t) c |= lsc_pkg::CODE_TOP;
    else if (y > win_b) c |= lsc_pkg::CODE_BOTTOM;
    return c;
  endfunction

  // base + (d * e) / den, truncated toward zero, saturated
  function automatic longint edge_point(longint base, longint d, longint e, longint den);
    longint unsigned md, me, mden, q;
    bit neg;
    if (den == 0) den = 1;
    neg  = ((d < 0) != (e < 0)) != (den < 0);
    md   = (d < 0) ? -d : d;
    me   = (e < 0) ? -e : e;
    mden = (den < 0) ? -den : den;
    q    = (md * me) / mden;
    if (q > (64'd1 << 34)) q = 64'd1 << 34;
    return sat_coord(neg ? base - longint'(q) : base + longint'(q));
  endfunction

  function automatic clip_t clip_segment(segment_t s);
    longint ax, ay, bx, by, dx, dy, nx, ny;
    logic [3:0] ca, cb, c;
    int pass;
    bit done, accepted;
    clip_t r;
    ax = longint'($signed(s.sx));
    ay = longint'($signed(s.sy));
    bx = longint'($signed(s.ex));
    by = longint'($signed(s.ey));
    ca = region_code(ax, ay);
    cb = region_code(bx, by);
    pass = 0;
    done = 1'b0;
    accepted = 1'b0;
    while (!done && pass < PASS_LIMIT) begin
      dx = bx - ax;
      dy = by - ay;
      if ((ca | cb) == 0) begin
        accepted = 1'b1;
        done = 1'b1;
      end else if ((ca & cb) != 0) begin
        done = 1'b1;
      end else begin
        c = (ca != 0) ? ca : cb;
        if ((c & lsc_pkg::CODE_BOTTOM) != 0) begin
          nx = edge_point(ax, dx, win_b - ay, dy);
          ny = win_b;
        end else if ((c & lsc_pkg::CODE_TOP) != 0) begin
          nx = edge_point(ax, dx, win_t - ay, dy);
          ny = win_t;
        end else if ((c & lsc_pkg::CODE_RIGHT) != 0) begin
          ny = edge_point(ay, dy, win_r - ax, dx);
          nx = win_r;
        end else begin
          ny = edge_point(ay, dy, win_l - ax, dx);
          nx = win_l;
        end
        if (c == ca) begin
          ax = nx;
          ay = ny;
          ca = region_code(ax, ay);
        end else begin
          bx = nx;
          by = ny;
          cb = region_code(bx, by);
        end
        pass++;
      end
    end
    r = '0;
    if (accepted) begin
      r.vis = 1'b1;
      r.sx  = ax[CW-1:0];
      r.sy  = ay[CW-1:0];
      r.ex  = bx[CW-1:0];
      r.ey  = by[CW-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= 200) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(string name, logic [CW-1:0] got_v, logic [CW-1:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("result %0d %s got %0d want %0d", n_out, name,
                                $signed(got_v), $signed(want_v)));
  endtask

  // config mirror, result check, then input accept: one block keeps the order fixed
  always @(posedge clk_i) begin : scoreboard
    clip_t got, want;
    segment_t s;
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_idx)
          lsc_pkg::REG_WINDOW_LEFT:   win_l = longint'($signed(cfg_data));
          lsc_pkg::REG_WINDOW_TOP:    win_t = longint'($signed(cfg_data));
          lsc_pkg::REG_WINDOW_RIGHT:  win_r = longint'($signed(cfg_data));
          lsc_pkg::REG_WINDOW_BOTTOM: win_b = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (pop && !empty) begin
        got.vis = visible;
        got.sx  = clip_sx;
        got.sy  = clip_sy;
        got.ex  = clip_ex;
        got.ey  = clip_ey;
        if (clip_expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none outstanding", n_out));
        end else begin
          want = clip_expected_q.pop_front();
          check_field("visible", {{(CW-1){1'b0}}, got.vis}, {{(CW-1){1'b0}}, want.vis});
          check_field("clipped_start_x", got.sx, want.sx);
          check_field("clipped_start_y", got.sy, want.sy);
          check_field("clipped_end_x", got.ex, want.ex);
          check_field("clipped_end_y", got.ey, want.ey);
        end
        if (got.vis === 1'b1) n_visible++;
        n_out++;
      end
      if (push && !full) begin
        s.sx = start_x;
        s.sy = start_y;
        s.ex = end_x;
        s.ey = end_y;
        clip_expected_q = {clip_expected_q, clip_segment(s)};
        void'(segment_pending_q.pop_front());
        n_in++;
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (push_gap > 0) begin
      push_gap <= push_gap - 1;
      push <= 1'b0;
    end else if (!calm && $urandom_range(99) < gap_rate) begin
      push_gap <= $urandom_range(18);
      push <= 1'b0;
    end else if (segment_pending_q.size() > 0) begin
      push <= 1'b1;
      start_x <= segment_pending_q[0].sx;
      start_y <= segment_pending_q[0].sy;
      end_x <= segment_pending_q[0].ex;
      end_y <= segment_pending_q[0].ey;
    end else begin
      push <= 1'b0;
    end
  end

  // result side stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(99) < gap_rate) begin
      pop_gap <= $urandom_range(18);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic write_reg(logic [lsc_pkg::CFG_IDX_WIDTH-1:0] idx, longint value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[CW-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_window(longint l, longint t, longint r, longint b);
    write_reg(lsc_pkg::REG_WINDOW_LEFT, l);
    write_reg(lsc_pkg::REG_WINDOW_TOP, t);
    write_reg(lsc_pkg::REG_WINDOW_RIGHT, r);
    write_reg(lsc_pkg::REG_WINDOW_BOTTOM, b);
    n_windows++;
  endtask

  task automatic wait_idle();
    while (segment_pending_q.size() != 0 || clip_expected_q.size() != 0)
      @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic add_seg(longint sx, longint sy, longint ex, longint ey);
    segment_t s;
    s.sx = sx[CW-1:0];
    s.sy = sy[CW-1:0];
    s.ex = ex[CW-1:0];
    s.ey = ey[CW-1:0];
    segment_pending_q = {segment_pending_q, s};
  endtask

  function automatic longint rand_span(longint lo, longint hi);
    if (lo < CMIN) lo = CMIN;
    if (hi > CMAX) hi = CMAX;
    return lo + longint'($urandom_range(int'(hi - lo)));
  endfunction

  function automatic longint pick_extreme();
    case ($urandom_range(5))
      0: return CMIN;
      1: return CMIN + 1;
      2: return CMAX;
      3: return CMAX - 1;
      4: return 0;
      default: return -1;
    endcase
  endfunction

  // mostly segments around the window so that clipping passes get exercised
  task automatic random_segments(int n);
    longint lo_x, hi_x, lo_y, hi_y, mx, my;
    int k, r;
    lo_x = (win_l < win_r) ? win_l : win_r;
    hi_x = (win_l < win_r) ? win_r : win_l;
    lo_y = (win_t < win_b) ? win_t : win_b;
    hi_y = (win_t < win_b) ? win_b : win_t;
    mx = (hi_x - lo_x) / 2 + 64;
    my = (hi_y - lo_y) / 2 + 64;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 65)
        add_seg(rand_span(lo_x - mx, hi_x + mx), rand_span(lo_y - my, hi_y + my),
                rand_span(lo_x - mx, hi_x + mx), rand_span(lo_y - my, hi_y + my));
      else if (r < 80)
        add_seg($urandom, $urandom, $urandom, $urandom);
      else if (r < 90)
        add_seg(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
      else
        add_seg(rand_span(lo_x - mx, hi_x + mx), rand_span(lo_y - my, hi_y + my),
                $urandom, $urandom);
    end
  endtask

  task automatic random_window(bit inverted);
    longint a, b, c, d, tmp;
    a = rand_span(-2000, 2000);
    b = rand_span(-2000, 2000);
    c = rand_span(-2000, 2000);
    d = rand_span(-2000, 2000);
    if ((a > b) != inverted) begin
      tmp = a; a = b; b = tmp;
    end
    if ((c > d) != inverted) begin
      tmp = c; c = d; d = tmp;
    end
    set_window(a, c, b, d);
  endtask

  initial begin : stimulus
    longint p;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset window: accept, reject, clips of one end and of both ends, extremes
    add_seg(100, 100, 200, 200);
    add_seg(-10, 5, -20, 100);
    add_seg(10, 600, 900, 700);
    add_seg(-100, 100, 100, 100);
    add_seg(500, 300, 1500, 300);
    add_seg(300, -50, 300, 100);
    add_seg(400, 200, 420, 900);
    add_seg(-100, -100, 1100, 700);
    add_seg(-100, 500, 100, 700);
    add_seg(CMIN, CMIN, CMAX, CMAX);
    add_seg(CMAX, CMIN, CMIN, CMAX);
    add_seg(5, 5, 5, 5);
    add_seg(CMIN, CMAX, CMIN, CMAX);
    add_seg(0, 0, 959, 539);
    wait_idle();

    // inverted window, extrapolating moves
    set_window(500, 400, 100, 50);
    add_seg(300, 200, 300, 200);
    add_seg(0, 0, 600, 500);
    add_seg(CMIN, 0, CMAX, 0);
    add_seg(200, CMIN, 250, CMAX);
    wait_idle();

    // fully inverted at the extremes, moves run into saturation
    set_window(CMAX, CMAX, CMIN, CMIN);
    add_seg(0, 0, 100, 100);
    add_seg(CMIN, CMIN, CMAX, CMAX);
    add_seg(-5, 3, 7, -9);
    wait_idle();

    // whole coordinate range inside
    set_window(CMIN, CMIN, CMAX, CMAX);
    add_seg(CMIN, CMAX, CMAX, CMIN);
    add_seg(0, 0, 1, 1);
    random_segments(60);
    wait_idle();

    gap_rate = 30;
    random_window(1'b0);
    random_segments(120);
    wait_idle();

    gap_rate = 0;
    random_window(1'b0);
    random_segments(120);
    wait_idle();

    gap_rate = 10;
    random_window(1'b0);
    random_segments(120);
    wait_idle();

    gap_rate = 25;
    random_window(1'b1);
    random_segments(120);
    wait_idle();

    // single-point window
    p = rand_span(-500, 500);
    set_window(p, p, p, p);
    random_segments(60);
    wait_idle();

    // arbitrary register contents
    gap_rate = 15;
    set_window($urandom, $urandom, $urandom, $urandom);
    random_segments(80);
    wait_idle();

    // last part without idling, back to the reset window
    calm = 1'b1;
    set_window(lsc_pkg::WIN_LEFT_RST, lsc_pkg::WIN_TOP_RST,
               lsc_pkg::WIN_RIGHT_RST, lsc_pkg::WIN_BOTTOM_RST);
    random_segments(120);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (clip_expected_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", clip_expected_q.size()));
    $display("covered %0d segments under %0d window settings: %0d visible, %0d not visible",
             n_in, n_windows + 1, n_visible, n_out - n_visible);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #25ms;
    $display("timeout with %0d results outstanding", clip_expected_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- line_segment_clipper_unit.f -----
+incdir+sv
sv/lsc_pkg.sv
sv/lsc_region.sv
sv/lsc_front.sv
sv/lsc_queue.sv
sv/lsc_back.sv
sv/line_segment_clipper_unit.sv
sv/lsc_checker.sv
dv/tb_line_segment_clipper_unit.sv
